// ===== rtl/core/ahi_pkg.sv =====
// ahi_pkg: shared types, register indexes and reset values for the
// adaptive heartbeat interval block. no dependencies.
package ahi_pkg;

    localparam int NOW_W      = 48;
    localparam int COUNT_W    = 8;
    localparam int RATE_W     = 24;
    localparam int INTERVAL_W = 16;
    localparam int WEIGHT_W   = 16;
    localparam int RUN_W      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_REARM = 1'b1;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTHING_WEIGHT    = 4'd0,
        CFG_HIGH_RATE_THRESHOLD = 4'd1,
        CFG_LOW_RATE_THRESHOLD  = 4'd2,
        CFG_HYSTERESIS_TICKS    = 4'd3,
        CFG_STEP_UP_MS          = 4'd4,
        CFG_STEP_DOWN_MS        = 4'd5,
        CFG_MIN_INTERVAL_MS     = 4'd6,
        CFG_MAX_INTERVAL_MS     = 4'd7
    } cfg_index_t;

    // reset values
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET    = 16'd4588;
    localparam logic [RATE_W-1:0]     HIGH_THR_RESET  = 24'd163840;
    localparam logic [RATE_W-1:0]     LOW_THR_RESET   = 24'd32768;
    localparam logic [RUN_W-1:0]      HYST_RESET      = 8'd10;
    localparam logic [INTERVAL_W-1:0] STEP_UP_RESET   = 16'd500;
    localparam logic [INTERVAL_W-1:0] STEP_DOWN_RESET = 16'd250;
    localparam logic [INTERVAL_W-1:0] MIN_IV_RESET    = 16'd5000;
    localparam logic [INTERVAL_W-1:0] MAX_IV_RESET    = 16'd10000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 16'd5000;

    typedef struct packed {
        logic [WEIGHT_W-1:0]   smoothing_weight;
        logic [RATE_W-1:0]     high_rate_threshold;
        logic [RATE_W-1:0]     low_rate_threshold;
        logic [RUN_W-1:0]      hysteresis_ticks;
        logic [INTERVAL_W-1:0] step_up_ms;
        logic [INTERVAL_W-1:0] step_down_ms;
        logic [INTERVAL_W-1:0] min_interval_ms;
        logic [INTERVAL_W-1:0] max_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [RATE_W-1:0]     smoothed_rate;
        logic [RUN_W-1:0]      backoff_run;
        logic [RUN_W-1:0]      recover_run;
        logic [INTERVAL_W-1:0] current_interval;
        logic [NOW_W-1:0]      next_deadline;
    } state_t;

endpackage

// ===== rtl/core/ahi_channels.sv =====
// ahi_channels: valid/ready channel interfaces for tick items and results.
// depends on ahi_pkg.
interface ahi_tick_if import ahi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [NOW_W-1:0]   now_ms;
    logic [COUNT_W-1:0] inbound_count;

    modport source (output valid, kind, now_ms, inbound_count, input ready);
    modport sink   (input valid, kind, now_ms, inbound_count, output ready);
endinterface

interface ahi_result_if import ahi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  fire_heartbeat;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [RATE_W-1:0]     rate_estimate;

    modport source (output valid, fire_heartbeat, interval_ms, rate_estimate, input ready);
    modport sink   (input valid, fire_heartbeat, interval_ms, rate_estimate, output ready);
endinterface

// ===== rtl/core/adaptive_heartbeat_interval.sv =====
// adaptive_heartbeat_interval: top level with input register, config
// registers, state and result register. depends on ahi_pkg, ahi_channels, ahi_update.
//
// usage:
//  - tick channel (sink): kind 0 is a timer tick carrying now_ms and the
//    inbound packet count, kind 1 rearms the deadline to now plus interval
//  - result channel (source): one item per input item with fire_heartbeat,
//    the interval after the item and the smoothed rate in q8.16
//  - config port: cfg_en writes cfg_data to register cfg_index at the clock
//    edge; unknown indexes are dropped; write only while the block is idle
//  - order: an accepted item is held in the input register, then its result
//    is registered in the result register and offered from there on
//  - throughput: one item per cycle while the receiver takes results; the ewma
//    multiply, run counters, interval clamp and deadline add are combinational
//    from the input register to the state and result registers
//  - receiver stall: the result register holds, the input register keeps
//    one more item, then tick.ready drops until the result is taken
//  - reset: registers return to their defaults, rate and runs to zero,
//    interval to 5000 ms, deadline to zero so the first tick fires
module adaptive_heartbeat_interval import ahi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ahi_tick_if.sink              tick,
    ahi_result_if.source          result
);

    // configuration registers
    cfg_t                  cfg_reg;

    // input register stage
    logic                  in_valid_reg;
    logic                  in_kind_reg;
    logic [NOW_W-1:0]      in_now_reg;
    logic [COUNT_W-1:0]    in_count_reg;

    // block state
    state_t                state_reg;
    state_t                state_next;

    // result register stage
    logic                  out_valid_reg;
    logic                  out_fire_reg;
    logic [INTERVAL_W-1:0] out_interval_reg;
    logic [RATE_W-1:0]     out_rate_reg;

    logic                  res_fire;
    logic [INTERVAL_W-1:0] res_interval;
    logic [RATE_W-1:0]     res_rate;

    logic                  advance;
    logic                  take_in;

    // item moves to the result register when that slot is free or drains now
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign take_in = tick.valid && tick.ready;

    assign tick.ready = !in_valid_reg || advance;

    // config writes, register index per the package enum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_weight    <= WEIGHT_RESET;
            cfg_reg.high_rate_threshold <= HIGH_THR_RESET;
            cfg_reg.low_rate_threshold  <= LOW_THR_RESET;
            cfg_reg.hysteresis_ticks    <= HYST_RESET;
            cfg_reg.step_up_ms          <= STEP_UP_RESET;
            cfg_reg.step_down_ms        <= STEP_DOWN_RESET;
            cfg_reg.min_interval_ms     <= MIN_IV_RESET;
            cfg_reg.max_interval_ms     <= MAX_IV_RESET;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_SMOOTHING_WEIGHT:    cfg_reg.smoothing_weight    <= cfg_data[15:0];
                CFG_HIGH_RATE_THRESHOLD: cfg_reg.high_rate_threshold <= cfg_data[23:0];
                CFG_LOW_RATE_THRESHOLD:  cfg_reg.low_rate_threshold  <= cfg_data[23:0];
                CFG_HYSTERESIS_TICKS:    cfg_reg.hysteresis_ticks    <= cfg_data[7:0];
                CFG_STEP_UP_MS:          cfg_reg.step_up_ms          <= cfg_data[15:0];
                CFG_STEP_DOWN_MS:        cfg_reg.step_down_ms        <= cfg_data[15:0];
                CFG_MIN_INTERVAL_MS:     cfg_reg.min_interval_ms     <= cfg_data[15:0];
                CFG_MAX_INTERVAL_MS:     cfg_reg.max_interval_ms     <= cfg_data[15:0];
                default:                 ;
            endcase
        end
    end

    // input register: control reset, payload loads on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_kind_reg  <= tick.kind;
            in_now_reg   <= tick.now_ms;
            in_count_reg <= tick.inbound_count;
        end
    end

    ahi_update u_update
    (
        .cfg            (cfg_reg),
        .state          (state_reg),
        .kind           (in_kind_reg),
        .now_ms         (in_now_reg),
        .inbound_count  (in_count_reg),
        .state_next     (state_next),
        .fire_heartbeat (res_fire),
        .interval_ms    (res_interval),
        .rate_estimate  (res_rate)
    );

    // state commits together with the result, so the next item sees it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.smoothed_rate    <= '0;
            state_reg.backoff_run      <= '0;
            state_reg.recover_run      <= '0;
            state_reg.current_interval <= INTERVAL_RESET;
            state_reg.next_deadline    <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_fire_reg     <= res_fire;
            out_interval_reg <= res_interval;
            out_rate_reg     <= res_rate;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.fire_heartbeat = out_fire_reg;
    assign result.interval_ms    = out_interval_reg;
    assign result.rate_estimate  = out_rate_reg;

    // every item leaving the input stage shows up as a result
    a_advance_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("item left input stage without a result");

    // state only changes when an item is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

    // the two hysteresis runs are never active together
    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((state_reg.backoff_run != '0) && (state_reg.recover_run != '0)))
        else $error("backoff and recover runs both nonzero");

    // back pressure only when the input stage holds an item that cannot move
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> (in_valid_reg && out_valid_reg && !result.ready))
        else $error("tick channel stalled without cause");

endmodule

// ===== rtl/core/ahi_update.sv =====
// ahi_update: one-pass next-state logic for a tick or rearm item:
// ewma rate, hysteresis runs, interval step and deadline. depends on ahi_pkg.
module ahi_update import ahi_pkg::*;
(
    input  cfg_t                  cfg,
    input  state_t                state,
    input  logic                  kind,
    input  logic [NOW_W-1:0]      now_ms,
    input  logic [COUNT_W-1:0]    inbound_count,
    output state_t                state_next,
    output logic                  fire_heartbeat,
    output logic [INTERVAL_W-1:0] interval_ms,
    output logic [RATE_W-1:0]     rate_estimate
);

    // rate + floor((a*(c<<16 - rate) + half) >> 16)
    logic signed [RATE_W:0]     rate_diff;
    logic signed [RATE_W+17:0]  rate_prod;
    logic signed [RATE_W+17:0]  rate_round;
    logic signed [RATE_W+1:0]   rate_adj;
    logic signed [RATE_W+1:0]   rate_sum;
    logic [RATE_W-1:0]          rate_new;

    logic [RUN_W-1:0]           hyst;
    logic [RUN_W-1:0]           backoff_inc;
    logic [RUN_W-1:0]           recover_inc;
    logic [RUN_W-1:0]           backoff_run;
    logic [RUN_W-1:0]           recover_run;
    logic                       step_up;
    logic                       step_down;

    logic [INTERVAL_W:0]        up_sum;
    logic [INTERVAL_W-1:0]      iv_up;
    logic signed [INTERVAL_W+1:0] dn_diff;
    logic [INTERVAL_W-1:0]      iv_new;
    logic                       due;

    assign rate_diff  = $signed({1'b0, inbound_count, 16'h0000})
                      - $signed({1'b0, state.smoothed_rate});
    assign rate_prod  = rate_diff * $signed({1'b0, cfg.smoothing_weight});
    assign rate_round = rate_prod + $signed((RATE_W+18)'(32768));
    assign rate_adj   = rate_round[RATE_W+17:16];
    assign rate_sum   = $signed({2'b00, state.smoothed_rate}) + rate_adj;
    assign rate_new   = rate_sum[RATE_W-1:0];

    assign hyst        = (cfg.hysteresis_ticks == '0) ? RUN_W'(1) : cfg.hysteresis_ticks;
    assign backoff_inc = (state.backoff_run == '1) ? state.backoff_run
                                                   : state.backoff_run + RUN_W'(1);
    assign recover_inc = (state.recover_run == '1) ? state.recover_run
                                                   : state.recover_run + RUN_W'(1);

    always_comb
    begin
        if (rate_new > cfg.high_rate_threshold)
        begin
            backoff_run = backoff_inc;
            recover_run = '0;
        end
        else if (rate_new < cfg.low_rate_threshold)
        begin
            backoff_run = '0;
            recover_run = recover_inc;
        end
        else
        begin
            backoff_run = '0;
            recover_run = '0;
        end
    end

    assign step_up   = (backoff_run >= hyst);
    assign step_down = (recover_run >= hyst);

    // step up clamps to max, then step down clamps to min, in that order
    assign up_sum = {1'b0, state.current_interval} + {1'b0, cfg.step_up_ms};
    assign iv_up  = !step_up ? state.current_interval
                  : (up_sum > {1'b0, cfg.max_interval_ms}) ? cfg.max_interval_ms
                  : up_sum[INTERVAL_W-1:0];
    assign dn_diff = $signed({2'b00, iv_up}) - $signed({2'b00, cfg.step_down_ms});
    assign iv_new  = !step_down ? iv_up
                   : (dn_diff < $signed({2'b00, cfg.min_interval_ms})) ? cfg.min_interval_ms
                   : dn_diff[INTERVAL_W-1:0];

    assign due = (now_ms >= state.next_deadline);

    always_comb
    begin
        state_next     = state;
        fire_heartbeat = 1'b0;
        if (kind == KIND_REARM)
        begin
            state_next.next_deadline = now_ms + {{(NOW_W-INTERVAL_W){1'b0}},
                                                 state.current_interval};
        end
        else
        begin
            state_next.smoothed_rate    = rate_new;
            state_next.backoff_run      = step_up ? '0 : backoff_run;
            state_next.recover_run      = step_down ? '0 : recover_run;
            state_next.current_interval = iv_new;
            if (due)
            begin
                fire_heartbeat           = 1'b1;
                state_next.next_deadline = state.next_deadline
                                         + {{(NOW_W-INTERVAL_W){1'b0}}, iv_new};
            end
        end
    end

    assign interval_ms   = state_next.current_interval;
    assign rate_estimate = state_next.smoothed_rate;

endmodule

// ===== tb/adaptive_heartbeat_interval_tb.sv =====
// adaptive_heartbeat_interval_tb: self-checking bench for the adaptive heartbeat interval block.
// a directed table, then randomized phases, scored against an in-bench predictor.
// depends on ahi_pkg, ahi_channels and adaptive_heartbeat_interval.
`timescale 1ns / 100ps

module adaptive_heartbeat_interval_tb;
    import ahi_pkg::*;

    // time range limit and an index that maps to no register
    localparam logic [NOW_W-1:0]     TOP_MS       = 48'hFFFF_FFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd15;
    // cycles without any handshake or write before the run is declared hung
    localparam int unsigned QUIET_LIMIT  = 2000;
    // settle time after the last result
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic                  fire;
        logic [INTERVAL_W-1:0] interval;
        logic [RATE_W-1:0]     rate;
    } beat_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0]   weight;
        logic [RATE_W-1:0]     high_thr;
        logic [RATE_W-1:0]     low_thr;
        logic [RUN_W-1:0]      hyst;
        logic [INTERVAL_W-1:0] step_up;
        logic [INTERVAL_W-1:0] step_down;
        logic [INTERVAL_W-1:0] min_iv;
        logic [INTERVAL_W-1:0] max_iv;
    } hb_regs_t;

    typedef struct packed {
        logic [RATE_W-1:0]     rate;
        logic [RUN_W-1:0]      backoff;
        logic [RUN_W-1:0]      recover;
        logic [INTERVAL_W-1:0] interval;
        logic [NOW_W-1:0]      deadline;
    } hb_state_t;

    typedef enum {ROW_ITEM, ROW_WRITE} row_op_t;
    typedef enum {LOAD_HEAVY, LOAD_QUIET, LOAD_ANY, LOAD_LIGHT} load_t;

    typedef struct {
        row_op_t               op;
        logic                  kind;
        logic [NOW_W-1:0]      now;
        logic [COUNT_W-1:0]    count;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    pin;
        beat_t                 want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ahi_tick_if   tick_ch ();
    ahi_result_if result_ch ();

    adaptive_heartbeat_interval dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .result    (result_ch)
    );

    // predictor copy of the registers and the block state
    hb_regs_t    regs_model;
    hb_state_t   beat_state;
    // results still owed by the block, oldest first
    beat_t       due_beats[$];
    plan_row_t   plan[$];
    // a directed row may carry a hand-computed result along with its item
    bit          pinned;
    beat_t       pinned_beat;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    // runs of back-to-back items on each side
    int unsigned send_calm;
    int unsigned take_calm;
    logic [NOW_W-1:0] wall_ms;
    load_t       load;
    int unsigned load_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void reset_model();
        regs_model.weight    = 16'd4588;
        regs_model.high_thr  = 24'd163840;
        regs_model.low_thr   = 24'd32768;
        regs_model.hyst      = 8'd10;
        regs_model.step_up   = 16'd500;
        regs_model.step_down = 16'd250;
        regs_model.min_iv    = 16'd5000;
        regs_model.max_iv    = 16'd10000;
        beat_state.rate      = '0;
        beat_state.backoff   = '0;
        beat_state.recover   = '0;
        beat_state.interval  = 16'd5000;
        beat_state.deadline  = '0;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SMOOTHING_WEIGHT:    regs_model.weight    = data[WEIGHT_W-1:0];
            CFG_HIGH_RATE_THRESHOLD: regs_model.high_thr  = data[RATE_W-1:0];
            CFG_LOW_RATE_THRESHOLD:  regs_model.low_thr   = data[RATE_W-1:0];
            CFG_HYSTERESIS_TICKS:    regs_model.hyst      = data[RUN_W-1:0];
            CFG_STEP_UP_MS:          regs_model.step_up   = data[INTERVAL_W-1:0];
            CFG_STEP_DOWN_MS:        regs_model.step_down = data[INTERVAL_W-1:0];
            CFG_MIN_INTERVAL_MS:     regs_model.min_iv    = data[INTERVAL_W-1:0];
            CFG_MAX_INTERVAL_MS:     regs_model.max_iv    = data[INTERVAL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [RUN_W-1:0] bump_run(logic [RUN_W-1:0] run);
        return (run == 8'hFF) ? run : run + 8'd1;
    endfunction

    // advances the predictor by one item and returns the result it should produce
    function automatic beat_t predict_beat(logic kind, logic [NOW_W-1:0] now,
                                           logic [COUNT_W-1:0] count);
        logic [63:0] wt;
        logic [63:0] acc;
        int          iv;
        int          hyst;
        beat_t       res;

        res.fire = 1'b0;
        if (kind == KIND_REARM)
        begin
            beat_state.deadline = now + beat_state.interval;
        end
        else
        begin
            // weighted mean in q8.16, round half up
            wt  = 64'(regs_model.weight);
            acc = wt * 64'(count) * 64'd65536
                + (64'd65536 - wt) * 64'(beat_state.rate) + 64'd32768;
            acc = acc >> 16;
            beat_state.rate = (acc > 64'hFF_FFFF) ? 24'hFF_FFFF : acc[RATE_W-1:0];

            if (beat_state.rate > regs_model.high_thr)
            begin
                beat_state.backoff = bump_run(beat_state.backoff);
                beat_state.recover = '0;
            end
            else if (beat_state.rate < regs_model.low_thr)
            begin
                beat_state.recover = bump_run(beat_state.recover);
                beat_state.backoff = '0;
            end
            else
            begin
                beat_state.backoff = '0;
                beat_state.recover = '0;
            end

            hyst = (regs_model.hyst == '0) ? 1 : int'(regs_model.hyst);
            iv   = int'(beat_state.interval);
            if (int'(beat_state.backoff) >= hyst)
            begin
                beat_state.backoff = '0;
                iv = iv + int'(regs_model.step_up);
                if (iv > int'(regs_model.max_iv))
                    iv = int'(regs_model.max_iv);
            end
            if (int'(beat_state.recover) >= hyst)
            begin
                beat_state.recover = '0;
                iv = iv - int'(regs_model.step_down);
                if (iv < int'(regs_model.min_iv))
                    iv = int'(regs_model.min_iv);
            end
            if (iv < 0)
                iv = 0;
            if (iv > 65535)
                iv = 65535;
            beat_state.interval = iv[INTERVAL_W-1:0];

            // on a fire the deadline advances by the interval just updated
            if (now >= beat_state.deadline)
            begin
                res.fire = 1'b1;
                beat_state.deadline = beat_state.deadline + beat_state.interval;
            end
        end
        res.interval = beat_state.interval;
        res.rate     = beat_state.rate;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // monitors
    // ---------------------------------------------------------------

    // config writes and accepted items feed the predictor at the same edge as the block
    always @(posedge clk)
    begin : track_items
        beat_t got;
        if (rst_n)
        begin
            if (cfg_en)
                apply_write(cfg_index, cfg_data);
            if (tick_ch.valid && tick_ch.ready)
            begin
                got = predict_beat(tick_ch.kind, tick_ch.now_ms, tick_ch.inbound_count);
                if (pinned)
                    got = pinned_beat;
                due_beats = {due_beats, got};
            end
        end
    end

    // every accepted result against the oldest expectation
    always @(posedge clk)
    begin : score_results
        beat_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (due_beats.size() == 0)
            begin
                $error("result with no item outstanding: fire %0d interval %0d rate %0d",
                       result_ch.fire_heartbeat, result_ch.interval_ms,
                       result_ch.rate_estimate);
                mismatches++;
            end
            else
            begin
                want = due_beats.pop_front();
                if (result_ch.fire_heartbeat !== want.fire)
                begin
                    $error("fire_heartbeat: expected %0d, got %0d",
                           want.fire, result_ch.fire_heartbeat);
                    mismatches++;
                end
                if (result_ch.interval_ms !== want.interval)
                begin
                    $error("interval_ms: expected %0d, got %0d",
                           want.interval, result_ch.interval_ms);
                    mismatches++;
                end
                if (result_ch.rate_estimate !== want.rate)
                begin
                    $error("rate_estimate: expected %0d, got %0d",
                           want.rate, result_ch.rate_estimate);
                    mismatches++;
                end
            end
        end
    end

    // hang detection: no item in, no item out, no write for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)
                    || cfg_en)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("adaptive_heartbeat_interval: mismatch");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // handshake drivers
    // ---------------------------------------------------------------

    // idle cycles before the next item; sometimes a run of zero gaps
    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // receiver: stall a random number of cycles before taking each result
    initial
    begin
        int unsigned gap;
        result_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = draw_gap(take_calm);
            if (gap != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
            @(negedge clk);
        end
    end

    // present one item after a random gap; valid stays up when the gap is zero
    task automatic send_tick(input logic kind, input logic [NOW_W-1:0] now,
                             input logic [COUNT_W-1:0] count, input bit pin,
                             input beat_t want);
        int unsigned gap;
        gap = draw_gap(send_calm);
        @(negedge clk);
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid         <= 1'b1;
        tick_ch.kind          <= kind;
        tick_ch.now_ms        <= now;
        tick_ch.inbound_count <= count;
        pinned                <= pin;
        pinned_beat           <= want;
        do @(posedge clk); while (!(tick_ch.valid && tick_ch.ready));
    endtask

    // drop valid and wait until every owed result has come back
    task automatic settle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic close_writes();
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------

    function automatic void add_item(logic kind, logic [NOW_W-1:0] now,
                                     logic [COUNT_W-1:0] count);
        plan_row_t row;
        row.op    = ROW_ITEM;
        row.kind  = kind;
        row.now   = now;
        row.count = count;
        row.idx   = '0;
        row.data  = '0;
        row.pin   = 1'b0;
        row.want  = '0;
        plan = {plan, row};
    endfunction

    function automatic void add_pinned(logic kind, logic [NOW_W-1:0] now,
                                       logic [COUNT_W-1:0] count, logic fire,
                                       logic [INTERVAL_W-1:0] iv, logic [RATE_W-1:0] rate);
        plan_row_t row;
        row.op            = ROW_ITEM;
        row.kind          = kind;
        row.now           = now;
        row.count         = count;
        row.idx           = '0;
        row.data          = '0;
        row.pin           = 1'b1;
        row.want.fire     = fire;
        row.want.interval = iv;
        row.want.rate     = rate;
        plan = {plan, row};
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row.op    = ROW_WRITE;
        row.kind  = KIND_TICK;
        row.now   = '0;
        row.count = '0;
        row.idx   = idx;
        row.data  = data;
        row.pin   = 1'b0;
        row.want  = '0;
        plan = {plan, row};
    endfunction

    // ---------------------------------------------------------------
    // random phases
    // ---------------------------------------------------------------

    function automatic logic [COUNT_W-1:0] draw_count(bit steady_load);
        logic [COUNT_W-1:0] c;
        // load level holds for a burst so the rate can drift across a threshold
        if (load_left == 0)
        begin
            load      = load_t'($urandom_range(0, 3));
            load_left = $urandom_range(3, 30);
        end
        load_left--;
        case (load)
            LOAD_HEAVY: c = COUNT_W'($urandom_range(128, 255));
            LOAD_QUIET: c = COUNT_W'($urandom_range(0, 1));
            LOAD_LIGHT: c = COUNT_W'($urandom_range(2, 6));
            default:    c = COUNT_W'($urandom_range(0, 255));
        endcase
        // steady load never lets the backoff run break
        if (steady_load && c == '0)
            c = 8'd1;
        return c;
    endfunction

    // write all registers while idle, then run n random items
    task automatic run_phase(input hb_regs_t s, input int unsigned n, input bit steady_load,
                             input logic [NOW_W-1:0] start_ms);
        int unsigned roll;
        logic [63:0] noise;
        settle();
        write_reg(CFG_SMOOTHING_WEIGHT, CFG_DATA_W'(s.weight));
        write_reg(CFG_HIGH_RATE_THRESHOLD, CFG_DATA_W'(s.high_thr));
        write_reg(CFG_LOW_RATE_THRESHOLD, CFG_DATA_W'(s.low_thr));
        write_reg(CFG_HYSTERESIS_TICKS, CFG_DATA_W'(s.hyst));
        write_reg(CFG_STEP_UP_MS, CFG_DATA_W'(s.step_up));
        write_reg(CFG_STEP_DOWN_MS, CFG_DATA_W'(s.step_down));
        write_reg(CFG_MIN_INTERVAL_MS, CFG_DATA_W'(s.min_iv));
        write_reg(CFG_MAX_INTERVAL_MS, CFG_DATA_W'(s.max_iv));
        close_writes();
        wall_ms = start_ms;
        for (int unsigned i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                // noise: any time, any kind unless the load is steady, a count drawn for the load
                noise = {$urandom, $urandom};
                send_tick(steady_load ? KIND_TICK : logic'($urandom_range(0, 1)),
                          noise[NOW_W-1:0], draw_count(steady_load), 1'b0, '0);
            end
            else if (roll < 13 && !steady_load)
            begin
                send_tick(KIND_REARM, wall_ms, COUNT_W'($urandom_range(0, 255)), 1'b0, '0);
            end
            else
            begin
                // time moves forward by up to about two intervals per tick
                wall_ms = wall_ms + $urandom_range(0, 2 * beat_state.interval + 2);
                send_tick(KIND_TICK, wall_ms, draw_count(steady_load), 1'b0, '0);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        hb_regs_t  s;
        plan_row_t row;
        bit        writing;
        logic [63:0] start;

        // every block input known from time zero
        rst_n                 = 1'b1;
        cfg_en                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.kind          = KIND_TICK;
        tick_ch.now_ms        = '0;
        tick_ch.inbound_count = '0;
        pinned                = 1'b0;
        pinned_beat           = '0;
        mismatches            = 0;
        quiet_cycles          = 0;
        send_calm             = 0;
        take_calm             = 0;
        load_left             = 0;
        load                  = LOAD_ANY;
        wall_ms               = '0;
        writing               = 1'b0;
        reset_model();

        // reset edge just after time zero so the asynchronous reset is seen
        #1;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first tick after reset: deadline is zero so it fires
        add_pinned(KIND_TICK, '0, 8'd0, 1'b1, 16'd5000, 24'd0);
        // rearm at the top of the time range; the deadline wraps to 4999
        add_pinned(KIND_REARM, TOP_MS, 8'hFF, 1'b0, 16'd5000, 24'd0);
        add_pinned(KIND_TICK, 48'd4998, 8'd0, 1'b0, 16'd5000, 24'd0);
        add_item(KIND_TICK, 48'd4999, 8'hFF);
        // zero weight: the rate holds whatever the count
        add_write(CFG_SMOOTHING_WEIGHT, 24'd0);
        add_item(KIND_TICK, 48'd5000, 8'hFF);
        add_item(KIND_TICK, 48'd5001, 8'd0);
        // full weight, zero hysteresis, everything is backoff, step to the top
        add_write(CFG_SMOOTHING_WEIGHT, 24'h00FFFF);
        add_write(CFG_HYSTERESIS_TICKS, 24'd0);
        add_write(CFG_HIGH_RATE_THRESHOLD, 24'd0);
        add_write(CFG_STEP_UP_MS, 24'h00FFFF);
        add_write(CFG_MAX_INTERVAL_MS, 24'h00FFFF);
        add_item(KIND_TICK, 48'd10000, 8'hFF);
        add_item(KIND_TICK, 48'd10001, 8'hFF);
        // thresholds at the top: everything is recover, step down to the floor
        add_write(CFG_HIGH_RATE_THRESHOLD, 24'hFFFFFF);
        add_write(CFG_LOW_RATE_THRESHOLD, 24'hFFFFFF);
        add_write(CFG_STEP_DOWN_MS, 24'h00FFFF);
        add_write(CFG_MIN_INTERVAL_MS, 24'd1);
        add_item(KIND_TICK, 48'd20000, 8'd0);
        add_item(KIND_TICK, 48'd20001, 8'd128);
        // min above max: up steps clamp to max, down steps clamp to min
        add_write(CFG_MIN_INTERVAL_MS, 24'd9000);
        add_write(CFG_MAX_INTERVAL_MS, 24'd6000);
        add_write(CFG_STEP_UP_MS, 24'd500);
        add_write(CFG_STEP_DOWN_MS, 24'd250);
        add_write(CFG_HIGH_RATE_THRESHOLD, 24'd0);
        add_write(CFG_LOW_RATE_THRESHOLD, 24'd0);
        add_item(KIND_TICK, 48'd30000, 8'hFF);
        add_item(KIND_TICK, 48'd30001, 8'hFF);
        add_write(CFG_HIGH_RATE_THRESHOLD, 24'hFFFFFF);
        add_write(CFG_LOW_RATE_THRESHOLD, 24'hFFFFFF);
        add_item(KIND_TICK, 48'd30002, 8'd0);
        add_item(KIND_TICK, 48'd30003, 8'd0);
        // a write to an unmapped index must change nothing
        add_write(CFG_UNMAPPED, 24'hFFFFFF);
        // middle band: both runs clear
        add_write(CFG_LOW_RATE_THRESHOLD, 24'd0);
        add_item(KIND_TICK, TOP_MS, 8'd100);
        add_item(KIND_REARM, '0, 8'd0);
        add_item(KIND_TICK, 48'hAAAA_AAAA_AAAA, 8'hAA);
        add_item(KIND_TICK, 48'h5555_5555_5555, 8'h55);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.op == ROW_WRITE)
            begin
                if (!writing)
                    settle();
                writing = 1'b1;
                write_reg(row.idx, row.data);
            end
            else
            begin
                if (writing)
                    close_writes();
                writing = 1'b0;
                send_tick(row.kind, row.now, row.count, row.pin, row.want);
            end
        end

        // back to the power-on defaults
        s = '{16'd4588, 24'd163840, 24'd32768, 8'd10, 16'd500, 16'd250, 16'd5000, 16'd10000};
        run_phase(s, 30, 1'b0, 48'd100000);

        // fast tracking, one-tick hysteresis
        s = '{16'hFFFF, 24'd200000, 24'd65536, 8'd1, 16'd1000, 16'd1000, 16'd1000, 16'd20000};
        run_phase(s, 30, 1'b0, 48'd200000);

        // extremes near the wrap point of the time range
        s = '{16'd1, 24'd0, 24'hFFFFFF, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        run_phase(s, 25, 1'b0, TOP_MS - 48'd20000);

        // two phases of arbitrary but sane settings
        repeat (2)
        begin
            s.weight    = WEIGHT_W'($urandom_range(1, 65535));
            s.high_thr  = RATE_W'($urandom_range(20000, 400000));
            s.low_thr   = RATE_W'($urandom_range(0, s.high_thr));
            s.hyst      = RUN_W'($urandom_range(1, 6));
            s.step_up   = INTERVAL_W'($urandom_range(0, 4000));
            s.step_down = INTERVAL_W'($urandom_range(0, 4000));
            s.min_iv    = INTERVAL_W'($urandom_range(1, 20000));
            s.max_iv    = INTERVAL_W'($urandom_range(s.min_iv, 65535));
            start       = {$urandom, $urandom};
            run_phase(s, 30, 1'b0, start[NOW_W-1:0]);
        end

        // min above max with live traffic
        s = '{16'd30000, 24'd131072, 24'd65536, 8'd2, 16'd700, 16'd300, 16'd40000, 16'd2000};
        run_phase(s, 30, 1'b0, 48'd5000000);

        // longest hysteresis under unbroken load: the backoff run climbs to 255
        s = '{16'hFFFF, 24'd0, 24'd0, 8'd255, 16'd123, 16'd0, 16'd1, 16'hFFFF};
        run_phase(s, 260, 1'b1, 48'd9000000);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("adaptive_heartbeat_interval: match");
        else
            $display("adaptive_heartbeat_interval: mismatch");
        $finish;
    end

endmodule
